[rtl/lir_pkg.sv]
package lir_pkg;

   localparam int SMP_W     = 16;
   localparam int RATE_W    = 18;
   localparam int RESID_W   = 20;
   localparam int FRAC_W    = 16;
   localparam int MAX_OUT   = 8;
   localparam int CNT_W     = $clog2(MAX_OUT + 1);
   localparam int DIV_CNT_W = 5;

   // Step counts of the shared divider for its two jobs.
   localparam logic [DIV_CNT_W-1:0] MOD_STEPS  = DIV_CNT_W'(RATE_W);
   localparam logic [DIV_CNT_W-1:0] FRAC_STEPS = DIV_CNT_W'(FRAC_W);

   localparam logic [RATE_W-1:0] SOURCE_RATE_RST = RATE_W'(44100);
   localparam logic [RATE_W-1:0] TARGET_RATE_RST = RATE_W'(48000);

   typedef enum logic {
      CSR_SOURCE_RATE = 1'b0,
      CSR_TARGET_RATE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAIR,
      ST_MOD,
      ST_FRAC,
      ST_FWAIT,
      ST_MUL_L,
      ST_ADD_L,
      ST_MUL_R,
      ST_ADD_R,
      ST_EMIT,
      ST_NEXT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [RATE_W-1:0]    init_rem;
      logic [RATE_W-1:0]    dividend;
      logic [RATE_W-1:0]    divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[rtl/lir_div.sv]
module lir_div (
   input  logic                       clock,
   input  logic                       reset,
   input  lir_pkg::div_req_type       req,
   output lir_pkg::div_stat_type      stat,
   output logic [lir_pkg::RATE_W-1:0] quotient,
   output logic [lir_pkg::RATE_W-1:0] remainder
);
   import lir_pkg::*;

   // Restoring divider, one quotient bit per cycle. The partial remainder
   // starts at init_rem and the dividend bits are shifted in from the top.
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W-1:0]    dvd_ff, dvd_in;
   logic [RATE_W-1:0]    quo_ff, quo_in;
   logic [RATE_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RATE_W:0]      trial;
   logic [RATE_W:0]      diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[RATE_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.init_rem;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         dvd_in = {dvd_ff[RATE_W-2:0], 1'b0};
         quo_in = {quo_ff[RATE_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/lir_mac.sv]
module lir_mac (
   input  logic                              clock,
   input  logic                              load,
   input  logic signed [lir_pkg::SMP_W-1:0]  s0,
   input  logic signed [lir_pkg::SMP_W-1:0]  s1,
   input  logic        [lir_pkg::FRAC_W-1:0] frac,
   output logic signed [lir_pkg::SMP_W-1:0]  result
);
   import lir_pkg::*;

   localparam int PROD_W = SMP_W + FRAC_W + 2;

   logic signed [SMP_W:0]    diff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SMP_W-1:0]  s0_ff, s0_in;

   // The arithmetic shift of the product floors toward minus infinity, which
   // is what the interpolation needs for both signs of the step.
   always_comb begin
      diff    = {s1[SMP_W-1], s1} - {s0[SMP_W-1], s0};
      prod_in = prod_ff;
      s0_in   = s0_ff;
      if (load) begin
         prod_in = PROD_W'(diff * $signed({1'b0, frac}));
         s0_in   = s0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      s0_ff   <= s0_in;
   end

   assign result = s0_ff + prod_ff[FRAC_W +: SMP_W];

endmodule

[rtl/linear_interp_resampler.sv]
// Stereo sample-rate converter by linear interpolation. Each req transfer
// carries one frame; the block keeps the previous frame and a phase residual
// and sends, as rsp transfers, every output frame whose position falls
// between the previous frame and the new one, at most eight per frame pair
// (rsp_tuser flags a pair whose further outputs were dropped). rsp_tlast
// marks the last output caused by a frame. On a frame with req_tlast the
// pair of that frame with itself is also worked, giving held copies, and the
// clip state is cleared. The very first frame of a clip only gets stored,
// unless it also carries req_tlast. Rates are to be written through the csr
// channel only while the block is idle, which the block itself does not
// enforce; a rate of zero behaves as one. One item is worked at a time and
// req_tready is low meanwhile. The shared serial divider forms the output
// count of each pair and the fraction of each output. A finished result
// waits in a pending register and then in the rsp output register, so a
// slow consumer stalls the work only when both of them hold a result.
module linear_interp_resampler (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: left_in [15:0], right_in [31:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: left_out [15:0], right_out [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: rate_overflow [0]
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [17:0] csr_data
);
   import lir_pkg::*;

   state_type state_ff, state_in;

   logic [RATE_W-1:0]  src_ff, src_in;
   logic [RATE_W-1:0]  tgt_ff, tgt_in;
   logic [RATE_W-1:0]  src_eff, tgt_eff;

   logic [SMP_W-1:0]   cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic               last_ff, last_in;
   logic [SMP_W-1:0]   prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic               have_prev_ff, have_prev_in;
   logic [RESID_W-1:0] resid_ff, resid_in;
   logic               pair_b_ff, pair_b_in;

   logic [RATE_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [SMP_W-1:0]   res_l_ff, res_l_in, res_r_ff, res_r_in;

   logic               pend_valid_ff, pend_valid_in;
   logic [SMP_W-1:0]   pend_l_ff, pend_l_in, pend_r_ff, pend_r_in;
   logic               pend_ovf_ff, pend_ovf_in;

   logic               out_valid_ff, out_valid_in;
   logic [SMP_W-1:0]   out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic               out_end_ff, out_end_in;
   logic               out_ovf_ff, out_ovf_in;

   logic               req_fire;
   logic               out_free;
   logic               out_load;
   logic               out_load_end;

   logic [SMP_W-1:0]   s0_l, s0_r;
   logic               mac_load;
   logic [SMP_W-1:0]   mac_s0, mac_s1, mac_result;

   div_req_type        div_req;
   div_stat_type       div_stat;
   logic [RATE_W-1:0]  div_quo, div_rem;

   logic               rem_nz;
   logic               pair_ovf;
   logic [CNT_W-1:0]   pair_emit;
   logic [RATE_W-1:0]  resid_lo;

   // Shared units: the serial divider works out both the output count of a
   // pair and the fraction of each output, the multiplier both channels.
   lir_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   lir_mac u_mac (
      .clock  (clock),
      .load   (mac_load),
      .s0     (mac_s0),
      .s1     (mac_s1),
      .frac   (frac_ff),
      .result (mac_result)
   );

   assign src_eff   = (src_ff == '0) ? RATE_W'(1) : src_ff;
   assign tgt_eff   = (tgt_ff == '0) ? RATE_W'(1) : tgt_ff;
   assign resid_lo  = resid_ff[RATE_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;

   // The first operand of a pair is the stored frame, or the current frame
   // itself when the closing pair of a clip is worked.
   assign s0_l   = pair_b_ff ? cur_l_ff : prev_l_ff;
   assign s0_r   = pair_b_ff ? cur_r_ff : prev_r_ff;
   assign mac_s0 = (state_ff == ST_MUL_R) ? s0_r : s0_l;
   assign mac_s1 = (state_ff == ST_MUL_R) ? cur_r_ff : cur_l_ff;
   assign mac_load = (state_ff == ST_MUL_L) || (state_ff == ST_MUL_R);

   // The gap to the end of the pair divided by the source rate gives the
   // output count, rounded up; the remainder gives the residual left past it.
   assign rem_nz    = (div_rem != '0);
   assign pair_ovf  = (div_quo > RATE_W'(MAX_OUT)) ||
                      ((div_quo == RATE_W'(MAX_OUT)) && rem_nz);
   assign pair_emit = pair_ovf ? CNT_W'(MAX_OUT) :
                      (div_quo[CNT_W-1:0] + CNT_W'(rem_nz));

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      cur_l_in      = cur_l_ff;
      cur_r_in      = cur_r_ff;
      last_in       = last_ff;
      prev_l_in     = prev_l_ff;
      prev_r_in     = prev_r_ff;
      have_prev_in  = have_prev_ff;
      resid_in      = resid_ff;
      pair_b_in     = pair_b_ff;
      rp_in         = rp_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      frac_in       = frac_ff;
      res_l_in      = res_l_ff;
      res_r_in      = res_r_ff;
      pend_valid_in = pend_valid_ff;
      pend_l_in     = pend_l_ff;
      pend_r_in     = pend_r_ff;
      pend_ovf_in   = pend_ovf_ff;
      out_load      = 1'b0;
      out_load_end  = 1'b0;
      div_req       = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_RATE: src_in = csr_data;
            CSR_TARGET_RATE: tgt_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_l_in = req_tdata[SMP_W-1:0];
               cur_r_in = req_tdata[2*SMP_W-1:SMP_W];
               last_in  = req_tlast;
               if (have_prev_ff) begin
                  pair_b_in = 1'b0;
                  state_in  = ST_PAIR;
               end else if (req_tlast) begin
                  pair_b_in = 1'b1;
                  state_in  = ST_PAIR;
               end else begin
                  // First frame of a clip: only stored.
                  prev_l_in    = req_tdata[SMP_W-1:0];
                  prev_r_in    = req_tdata[2*SMP_W-1:SMP_W];
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_PAIR: begin
            if (resid_ff < RESID_W'(tgt_eff)) begin
               div_req.start    = 1'b1;
               div_req.init_rem = '0;
               div_req.dividend = tgt_eff - resid_lo;
               div_req.divisor  = src_eff;
               div_req.steps    = MOD_STEPS;
               state_in         = ST_MOD;
            end else begin
               // The residual is already past this pair, which happens when
               // the rates change within a clip: no output, just move on.
               resid_in = resid_ff - RESID_W'(tgt_eff);
               state_in = ST_NEXT;
            end
         end
         ST_MOD: begin
            if (div_stat.done) begin
               rp_in    = resid_lo;
               cnt_in   = pair_emit;
               ovf_in   = pair_ovf;
               resid_in = rem_nz ? RESID_W'(src_eff - div_rem) : '0;
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            div_req.start    = 1'b1;
            div_req.init_rem = rp_ff;
            div_req.dividend = '0;
            div_req.divisor  = tgt_eff;
            div_req.steps    = FRAC_STEPS;
            state_in         = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (div_stat.done) begin
               frac_in  = div_quo[FRAC_W-1:0];
               state_in = ST_MUL_L;
            end
         end
         ST_MUL_L: state_in = ST_ADD_L;
         ST_ADD_L: begin
            res_l_in = mac_result;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: state_in = ST_ADD_R;
         ST_ADD_R: begin
            res_r_in = mac_result;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // The newest result stays pending until it is known whether it
            // ends the run for this frame.
            if (!pend_valid_ff || out_free) begin
               out_load      = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_l_in     = res_l_ff;
               pend_r_in     = res_r_ff;
               pend_ovf_in   = ovf_ff;
               rp_in         = rp_ff + src_eff;
               cnt_in        = cnt_ff - CNT_W'(1);
               state_in      = (cnt_ff == CNT_W'(1)) ? ST_NEXT : ST_FRAC;
            end
         end
         ST_NEXT: begin
            if (!pair_b_ff && last_ff) begin
               pair_b_in = 1'b1;
               state_in  = ST_PAIR;
            end else begin
               if (last_ff) begin
                  prev_l_in    = '0;
                  prev_r_in    = '0;
                  resid_in     = '0;
                  have_prev_in = 1'b0;
               end else begin
                  prev_l_in    = cur_l_ff;
                  prev_r_in    = cur_r_ff;
                  have_prev_in = 1'b1;
               end
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_load_end  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      out_end_in   = out_end_ff;
      out_ovf_in   = out_ovf_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_l_in     = pend_l_ff;
         out_r_in     = pend_r_ff;
         out_end_in   = out_load_end;
         out_ovf_in   = pend_ovf_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         src_ff        <= SOURCE_RATE_RST;
         tgt_ff        <= TARGET_RATE_RST;
         prev_l_ff     <= '0;
         prev_r_ff     <= '0;
         have_prev_ff  <= 1'b0;
         resid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         src_ff        <= src_in;
         tgt_ff        <= tgt_in;
         prev_l_ff     <= prev_l_in;
         prev_r_ff     <= prev_r_in;
         have_prev_ff  <= have_prev_in;
         resid_ff      <= resid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
      end
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      last_ff     <= last_in;
      pair_b_ff   <= pair_b_in;
      rp_ff       <= rp_in;
      ovf_ff      <= ovf_in;
      frac_ff     <= frac_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      pend_l_ff   <= pend_l_in;
      pend_r_ff   <= pend_r_in;
      pend_ovf_ff <= pend_ovf_in;
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
      out_end_ff  <= out_end_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_r_ff, out_l_ff};
   assign rsp_tlast  = out_end_ff;
   assign rsp_tuser  = out_ovf_ff;

`ifndef ASSERT_OFF
   // No item is taken while the divider still works on the previous one.
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while idle");

   // Every result of an item has left the pending stage before the next item.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind at idle");

   // Divider results arrive only where the sequencer waits for them.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> ((state_ff == ST_MOD) || (state_ff == ST_FWAIT)))
      else $error("divider finished outside a wait state");

   // A pair never emits more than the output limit.
   a_emit_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_OUT))
      else $error("output count beyond limit");

   // Between clips the phase residual rests at zero.
   a_clip_resid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !have_prev_ff) |-> (resid_ff == '0))
      else $error("residual not cleared between clips");
`endif

endmodule

[dv/linear_interp_resampler_tb.sv]
`timescale 1ns / 100ps

module linear_interp_resampler_tb;

   import lir_pkg::*;

   // Clock period, run limits and the settle time that follows the last
   // expected output before the rates may be rewritten, long enough for the
   // block to finish a frame with no output.
   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 111;
   localparam int RATE_MAX     = 192000;

   // One output frame as the block should present it on the rsp channel.
   typedef struct {
      logic [SMP_W-1:0] left;
      logic [SMP_W-1:0] right;
      logic             run_end;
      logic             overflow;
   } out_frame_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata = '0;   // left_in [15:0], right_in [31:16]
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;        // left_out [15:0], right_out [31:16]
   logic                rsp_tlast;
   logic                rsp_tuser;        // rate_overflow [0]
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_SOURCE_RATE;
   logic [RATE_W-1:0]   csr_data = '0;

   // Shadow state of the converter, updated as transfers are accepted.
   logic [RATE_W-1:0]   src_hz;
   logic [RATE_W-1:0]   tgt_hz;
   logic signed [SMP_W-1:0] held_left;
   logic signed [SMP_W-1:0] held_right;
   logic [RESID_W-1:0]  phase_acc;
   logic                held_valid;

   // Output frames predicted but not yet seen, oldest first.
   out_frame_type       pending_out[$];

   int unsigned         fail_count = 0;
   int unsigned         cycle_count = 0;
   // When clear, neither side inserts idle cycles.
   logic                stall_on = 1'b1;

   linear_interp_resampler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Interpolation of one channel: s0 plus the floored product of the step
   // and the 16-bit fraction. The arithmetic shift floors negative products.
   function automatic logic [SMP_W-1:0] blend(input logic signed [SMP_W-1:0] s0,
                                              input logic signed [SMP_W-1:0] s1,
                                              input longint unsigned frac);
      longint prod;
      prod = (longint'(s1) - longint'(s0)) * longint'(frac);
      return SMP_W'(longint'(s0) + (prod >>> FRAC_W));
   endfunction

   // Works one frame pair: every output position still inside the pair is
   // emitted, up to MAX_OUT of them. Dropped outputs still advance the phase.
   task automatic interp_span(input logic signed [SMP_W-1:0] l0,
                              input logic signed [SMP_W-1:0] r0,
                              input logic signed [SMP_W-1:0] l1,
                              input logic signed [SMP_W-1:0] r1);
      longint unsigned src;
      longint unsigned tgt;
      longint unsigned pos;
      longint unsigned n_out;
      longint unsigned n_emit;
      longint unsigned frac;
      logic            ovf;
      out_frame_type   item;
      // A rate register at zero behaves as a rate of one.
      src = (src_hz == 0) ? 1 : src_hz;
      tgt = (tgt_hz == 0) ? 1 : tgt_hz;
      pos = phase_acc;
      n_out = 0;
      // A residual already past the pair (rates changed mid-clip) gives
      // no outputs at all.
      if (pos < tgt) n_out = (tgt - pos + src - 1) / src;
      ovf = (n_out > MAX_OUT);
      n_emit = ovf ? MAX_OUT : n_out;
      for (longint unsigned i = 0; i < n_emit; i++) begin
         frac = ((pos + i * src) << FRAC_W) / tgt;
         item.left = blend(l0, l1, frac);
         item.right = blend(r0, r1, frac);
         item.run_end = 1'b0;
         item.overflow = ovf;
         pending_out.insert(pending_out.size(), item);
      end
      phase_acc = RESID_W'(pos + n_out * src - tgt);
   endtask

   // Expected outputs of one accepted frame. The first frame of a clip is
   // only stored unless it is also the last; the last frame is also paired
   // with itself, which yields held copies, and then the clip state clears.
   task automatic predict_frame(input logic signed [SMP_W-1:0] left,
                                input logic signed [SMP_W-1:0] right,
                                input logic last);
      int unsigned count_in;
      count_in = pending_out.size();
      if (held_valid) interp_span(held_left, held_right, left, right);
      if (last) begin
         interp_span(left, right, left, right);
         held_left = '0;
         held_right = '0;
         phase_acc = '0;
         held_valid = 1'b0;
      end else begin
         held_left = left;
         held_right = right;
         held_valid = 1'b1;
      end
      if (pending_out.size() > count_in)
         pending_out[pending_out.size() - 1].run_end = 1'b1;
   endtask

   // Offers one frame on the req channel and waits for its transfer. A random
   // gap may precede it; otherwise valid stays high across back-to-back frames.
   task automatic send_frame(input logic [SMP_W-1:0] left,
                             input logic [SMP_W-1:0] right,
                             input logic last);
      if (stall_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frame(left, right, last);
   endtask

   // Writes one rate register; only called while the block is idle.
   task automatic write_rate(input csr_index_type idx, input logic [RATE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SOURCE_RATE) src_hz = value;
      else tgt_hz = value;
   endtask

   // Stops offering frames, waits for every expected output, then lets the
   // block finish any frame that produces nothing.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reset rates (44.1 kHz to 48 kHz). The first frame of a clip is only
   // stored, full-scale steps in both directions exercise the rounding, and
   // a clip made of a single last frame yields held copies only.
   task automatic test_reset_rates();
      send_frame(16'h0000, 16'h0000, 1'b0);
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'hFFFF, 16'h0001, 1'b0);
      send_frame(16'h3039, 16'hCFC7, 1'b1);
      send_frame(16'h8000, 16'h7FFF, 1'b1);
      wait_idle();
   endtask

   // Strong upsampling: each pair wants far more than eight outputs, so the
   // excess is dropped and every output carries the overflow flag. The last
   // frame then gives two full pairs.
   task automatic test_overflow();
      write_rate(CSR_SOURCE_RATE, 18'd1000);
      write_rate(CSR_TARGET_RATE, 18'(RATE_MAX));
      send_frame(16'h0064, 16'hFF9C, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h7FFF, 16'h8000, 1'b1);
      wait_idle();
   endtask

   // Both rates at zero behave as rates of one: one output per pair.
   task automatic test_zero_rates();
      write_rate(CSR_SOURCE_RATE, 18'd0);
      write_rate(CSR_TARGET_RATE, 18'd0);
      send_frame(16'h0005, 16'hFFFB, 1'b0);
      send_frame(16'hFFF9, 16'h0007, 1'b1);
      wait_idle();
   endtask

   // The target rate drops while a clip is open, so the stored residual lies
   // beyond the next pair, which then emits nothing.
   task automatic test_rate_change();
      write_rate(CSR_SOURCE_RATE, 18'd44100);
      write_rate(CSR_TARGET_RATE, 18'd48000);
      send_frame(16'h1000, 16'hF000, 1'b0);
      send_frame(16'h2000, 16'hE000, 1'b0);
      wait_idle();
      write_rate(CSR_TARGET_RATE, 18'd1000);
      send_frame(16'h4000, 16'hC000, 1'b0);
      send_frame(16'h7FFF, 16'h8000, 1'b1);
      wait_idle();
   endtask

   // Extreme downsampling: most pairs fall short of the next output.
   task automatic test_downsample();
      write_rate(CSR_SOURCE_RATE, 18'(RATE_MAX));
      write_rate(CSR_TARGET_RATE, 18'd1);
      send_frame(16'hAAAA, 16'h5555, 1'b0);
      send_frame(16'h5555, 16'hAAAA, 1'b0);
      send_frame(16'h0000, 16'hFFFF, 1'b0);
      send_frame(16'hFFFF, 16'h0000, 1'b1);
      wait_idle();
   endtask

   function automatic logic [SMP_W-1:0] random_sample();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return SMP_W'($urandom);
      endcase
   endfunction

   // Random phases: each picks new rates (mostly moderate upsampling ratios
   // so that pairs produce several outputs, sometimes anything in range) and
   // sends clips of random length with random samples. Clips may span phases.
   // One phase runs with no idle cycles on either side.
   task automatic test_random_clips();
      int unsigned sent;
      int unsigned phase;
      int unsigned src;
      int unsigned tgt;
      int unsigned n_phase;
      int unsigned clip_len;
      int unsigned k;
      logic        last;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         stall_on = (phase != 1);
         if ($urandom_range(3) == 0) begin
            src = $urandom_range(1, RATE_MAX);
            tgt = $urandom_range(1, RATE_MAX);
         end else begin
            src = $urandom_range(8000, RATE_MAX);
            tgt = src / 4 + $urandom_range(0, src * 6 - src / 4);
            if (tgt > RATE_MAX) tgt = RATE_MAX;
         end
         if ($urandom_range(1)) begin
            write_rate(CSR_SOURCE_RATE, RATE_W'(src));
            write_rate(CSR_TARGET_RATE, RATE_W'(tgt));
         end else begin
            write_rate(CSR_TARGET_RATE, RATE_W'(tgt));
            write_rate(CSR_SOURCE_RATE, RATE_W'(src));
         end
         n_phase = $urandom_range(10, 30);
         clip_len = $urandom_range(1, 12);
         k = 0;
         while (n_phase != 0 && sent < RANDOM_ITEMS) begin
            k++;
            // Clip ends at its length; now and then a stray last mark.
            last = (k >= clip_len) || ($urandom_range(19) == 0);
            send_frame(random_sample(), random_sample(), last);
            if (last) begin
               k = 0;
               clip_len = $urandom_range(1, 12);
            end
            sent++;
            n_phase--;
         end
         wait_idle();
         phase++;
      end
      stall_on = 1'b1;
   endtask

   // Result checker and consumer: each rsp transfer is compared with the
   // oldest expected output, then the ready for the next edge is chosen.
   always @(posedge clock) begin
      out_frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            $error("unexpected rsp transfer: left_out %0d right_out %0d",
                   $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]));
            fail_count++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata[15:0] !== want.left) begin
               $error("left_out: expected %0d, got %0d",
                      $signed(want.left), $signed(rsp_tdata[15:0]));
               fail_count++;
            end
            if (rsp_tdata[31:16] !== want.right) begin
               $error("right_out: expected %0d, got %0d",
                      $signed(want.right), $signed(rsp_tdata[31:16]));
               fail_count++;
            end
            if (rsp_tlast !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $error("rate_overflow: expected %0d, got %0d", want.overflow, rsp_tuser);
               fail_count++;
            end
         end
      end
      rsp_tready <= !stall_on || ($urandom_range(99) >= 32);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      src_hz = SOURCE_RATE_RST;
      tgt_hz = TARGET_RATE_RST;
      held_left = '0;
      held_right = '0;
      phase_acc = '0;
      held_valid = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_rates();
      test_overflow();
      test_zero_rates();
      test_rate_change();
      test_downsample();
      test_random_clips();

      // Anything still expected at this point was never delivered.
      if (pending_out.size() != 0) begin
         $error("%0d expected outputs never arrived", pending_out.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
